// File: src/assert_macros.svh
// assertion macros used by the checker file dces_checker.sv
// expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on clk, off while reset is asserted
`define CHK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// same cycle implication
`define CHK_IMPLY(label, ante, cons, msg) \
	`CHK_ASSERT(label, (ante) |-> (cons), msg)

`endif

// File: src/dces_pkg.sv
// shared types and constants of the daily color event scheduler
// no dependencies
`default_nettype none

package dces_pkg;

	// opcodes carried in s_tuser
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_CHECK = 2'd3;

	// result kinds carried in m_tuser
	localparam logic KIND_ADD_REPLY = 1'b0;
	localparam logic KIND_DUE       = 1'b1;

	localparam logic [15:0] FREE_MARK     = 16'hFFFF;
	localparam logic [23:0] WHITE         = 24'hFFFFFF;
	localparam logic [15:0] TPD_RESET     = 16'd43200;
	localparam logic [4:0]  TICKS_PER_MIN = 5'd30;

	localparam int MAX_RESULTS = 8;
	localparam int HIT_W       = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic [15:0] wakeup;
		logic [23:0] color;
	} slot_entry_t;

endpackage

`default_nettype wire

// File: src/dces_slot_mem.sv
// slot table memory: one write port, one registered read port, valid bits
// depends on dces_pkg
`default_nettype none

module dces_slot_mem #(
	parameter int SLOTS = 8
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          clear,
	input  wire logic                                          rd_en,
	input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]  rd_idx,
	output dces_pkg::slot_entry_t                              rd_data,
	input  wire logic                                          wr_en,
	input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]  wr_idx,
	input  wire dces_pkg::slot_entry_t                         wr_data
);
	import dces_pkg::*;

	slot_entry_t mem [SLOTS];
	logic [SLOTS-1:0] valid_q;
	slot_entry_t rdata_q;
	logic rvalid_q;

	// never-written or cleared entries read as free and white
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q  <= mem[rd_idx];
			rvalid_q <= valid_q[rd_idx];
		end
	end

	assign rd_data = rvalid_q ? rdata_q : slot_entry_t'{wakeup: FREE_MARK, color: WHITE};

endmodule

`default_nettype wire

// File: src/daily_color_event_scheduler.sv
// top level of the daily color event scheduler: stream ports, day timer, slot scan
// depends on dces_pkg and dces_slot_mem
`default_nettype none

// Keeps EVENT_SLOTS daily color events in a slot memory next to a day timer that
// counts down from ticks_per_day to 1, one step per tick word. The opcode in
// s_tuser selects clear, add, tick or check. Clear and tick finish in the cycle
// the word is accepted and give no result. Add and check walk the slot memory
// one slot per cycle through its single registered read port while the output
// register can take a word; a stalled m_tready holds the walk. Add returns one
// reply word. Check returns one word per due slot (at most 8), tlast on the
// final one, which is released in a flush step after the walk. While add or
// check runs, s_tready is low; a finished result may wait in the output register
// while the next word is accepted. ticks_per_day is written through
// cfg_we/cfg_wdata; the user must do so only while idle, as the block does not
// enforce it. A write does not disturb the running timer.
module daily_color_event_scheduler #(
	parameter int EVENT_SLOTS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: ticks_per_day
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	// input words
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // minute[5:0], second[11:6], red[19:12],
	                                   // green[27:20], blue[35:28], zero pad
	input  wire logic [1:0]  s_tuser,  // opcode[1:0]
	// result words
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // accepted[0], slot[3:1], red[11:4],
	                                   // green[19:12], blue[27:20], zero pad
	output logic             m_tuser,  // kind[0]
	output logic             m_tlast
);
	import dces_pkg::*;

	localparam int IW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
	localparam int CW = $clog2(EVENT_SLOTS + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	// control and configuration state
	logic [1:0]  state_q;
	logic [15:0] tpd_q;
	logic [15:0] day_q;
	logic        is_add_q;
	logic [CW-1:0] rd_idx_q;

	// pending add payload
	logic [15:0] wake_q;
	logic [23:0] color_q;

	// read stage
	logic          v_s1;
	logic [IW-1:0] idx_s1;
	slot_entry_t   ent;

	// one due slot is held back until we know whether another follows
	logic             held_q;
	logic [2:0]       held_slot_q;
	logic [23:0]      held_color_q;
	logic [HIT_W-1:0] hits_q;

	// output register
	logic        m_valid_q;
	logic        out_kind_q;
	logic        out_acc_q;
	logic [2:0]  out_slot_q;
	logic [23:0] out_color_q;
	logic        out_last_q;

	// input field unpack
	logic [5:0]  in_minute;
	logic [5:0]  in_second;
	logic [23:0] in_color;
	logic [10:0] min_ticks;
	logic [15:0] new_wake;
	logic [15:0] day_dec;
	logic        s_acc;

	assign in_minute = s_tdata[5:0];
	assign in_second = s_tdata[11:6];
	assign in_color  = s_tdata[35:12] == 24'h0 ? 24'h0
	                 : {s_tdata[19:12], s_tdata[27:20], s_tdata[35:28]};
	assign min_ticks = {5'd0, in_minute} * {6'd0, TICKS_PER_MIN};
	// wakeup = ticks_per_day - minute*30 - second/2, wraps at 16 bits
	assign new_wake  = tpd_q - {5'd0, min_ticks} - {11'd0, in_second[5:1]};
	assign day_dec   = day_q - 16'd1;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// scan control
	logic out_free, go, is_free, hit, last_slot;
	logic [IW+2:0] idx_ext;
	logic [2:0]    slot3;
	logic push, p_kind, p_acc, p_last;
	logic [2:0]  p_slot;
	logic [23:0] p_color;
	logic wr_en, stop, to_flush, take_hit, rd_en, mem_clear;

	assign out_free  = !m_valid_q || m_tready;
	assign go        = !v_s1 || out_free;
	assign is_free   = (ent.wakeup == FREE_MARK);
	assign hit       = !is_free && (ent.wakeup == day_q);
	assign last_slot = (idx_s1 == IW'(EVENT_SLOTS - 1));
	assign idx_ext   = {3'd0, idx_s1};
	assign slot3     = idx_ext[2:0];
	assign mem_clear = s_acc && (s_tuser == OP_CLEAR);

	always_comb begin
		push     = 1'b0;
		p_kind   = KIND_ADD_REPLY;
		p_acc    = 1'b0;
		p_slot   = 3'd0;
		p_color  = 24'h0;
		p_last   = 1'b0;
		wr_en    = 1'b0;
		stop     = 1'b0;
		to_flush = 1'b0;
		take_hit = 1'b0;
		if (state_q == ST_SCAN && v_s1 && out_free) begin
			if (is_add_q) begin
				// first free slot takes the event
				if (is_free) begin
					wr_en  = 1'b1;
					push   = 1'b1;
					p_acc  = 1'b1;
					p_slot = slot3;
					p_last = 1'b1;
					stop   = 1'b1;
				end else if (last_slot) begin
					// table full
					push   = 1'b1;
					p_last = 1'b1;
					stop   = 1'b1;
				end
			end else begin
				if (hit) begin
					take_hit = 1'b1;
					// a newer hit releases the held one without tlast
					if (held_q) begin
						push    = 1'b1;
						p_kind  = KIND_DUE;
						p_acc   = 1'b1;
						p_slot  = held_slot_q;
						p_color = held_color_q;
					end
					if (hits_q == HIT_W'(MAX_RESULTS - 1) || last_slot) begin
						stop     = 1'b1;
						to_flush = 1'b1;
					end
				end else if (last_slot) begin
					stop     = 1'b1;
					to_flush = held_q;
				end
			end
		end else if (state_q == ST_FLUSH && out_free) begin
			push    = 1'b1;
			p_kind  = KIND_DUE;
			p_acc   = 1'b1;
			p_slot  = held_slot_q;
			p_color = held_color_q;
			p_last  = 1'b1;
		end
	end

	assign rd_en = (state_q == ST_SCAN) && go && !stop && (rd_idx_q < CW'(EVENT_SLOTS));

	dces_slot_mem #(
		.SLOTS (EVENT_SLOTS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (mem_clear),
		.rd_en   (rd_en),
		.rd_idx  (rd_idx_q[IW-1:0]),
		.rd_data (ent),
		.wr_en   (wr_en),
		.wr_idx  (idx_s1),
		.wr_data (slot_entry_t'{wakeup: wake_q, color: color_q})
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpd_q <= TPD_RESET;
		end else if (cfg_we) begin
			tpd_q <= cfg_wdata;
		end
	end

	// sequencer, day timer and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			day_q    <= TPD_RESET;
			is_add_q <= 1'b0;
			rd_idx_q <= '0;
			v_s1     <= 1'b0;
			held_q   <= 1'b0;
			hits_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						unique case (s_tuser)
							OP_CLEAR: begin
								day_q <= tpd_q;
							end
							OP_ADD: begin
								is_add_q <= 1'b1;
								rd_idx_q <= '0;
								state_q  <= ST_SCAN;
							end
							OP_TICK: begin
								// reload when the decrement lands on zero
								day_q <= (day_dec == 16'd0) ? tpd_q : day_dec;
							end
							OP_CHECK: begin
								is_add_q <= 1'b0;
								rd_idx_q <= '0;
								held_q   <= 1'b0;
								hits_q   <= '0;
								state_q  <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CW'(1);
						v_s1     <= 1'b1;
					end else if (go) begin
						v_s1 <= 1'b0;
					end
					if (take_hit) begin
						held_q <= 1'b1;
						hits_q <= hits_q + HIT_W'(1);
					end
					if (stop) begin
						state_q <= to_flush ? ST_FLUSH : ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						held_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload of the pending add, of the read stage and of the held hit
	always_ff @(posedge clk) begin
		if (s_acc && s_tuser == OP_ADD) begin
			wake_q  <= new_wake;
			color_q <= in_color;
		end
		if (rd_en) begin
			idx_s1 <= rd_idx_q[IW-1:0];
		end
		if (take_hit) begin
			held_slot_q  <= slot3;
			held_color_q <= ent.color;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (push) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_kind_q  <= p_kind;
			out_acc_q   <= p_acc;
			out_slot_q  <= p_slot;
			out_color_q <= p_color;
			out_last_q  <= p_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, out_color_q[7:0], out_color_q[15:8], out_color_q[23:16],
	                   out_slot_q, out_acc_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// File: src/dces_checker.sv
// port-level checker for the daily color event scheduler, bound to the top level
// depends on dces_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module dces_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);
	import dces_pkg::*;

	// a waiting result word is not withdrawn
	`CHK_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> m_tvalid, "result word dropped while stalled")

	// an add reply is a single word with no color
	`CHK_IMPLY(a_add_reply, (m_tvalid && m_tuser == KIND_ADD_REPLY), (m_tlast && m_tdata[27:4] == 24'h0), "add reply malformed")

	// a full table replies with slot zero
	`CHK_IMPLY(a_full_slot, (m_tvalid && m_tuser == KIND_ADD_REPLY && !m_tdata[0]), (m_tdata[3:1] == 3'd0), "rejected add reports a slot")

	// due events are always flagged accepted
	`CHK_IMPLY(a_due_acc, (m_tvalid && m_tuser == KIND_DUE), m_tdata[0], "due event without accepted")

	// an add always occupies the block for its slot walk
	`CHK_ASSERT(a_add_busy, (s_tvalid && s_tready && s_tuser == OP_ADD) |=> !s_tready, "input taken during add")

endmodule

bind daily_color_event_scheduler dces_checker u_dces_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
